/* rtl/core/rbs_pkg.sv */
package rbs_pkg;

  localparam int MaxPoints = 1024;
  localparam int AddrW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int CountW = $clog2(MaxPoints + 1);

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic               last_point;
  } in_word_t;

  typedef struct packed {
    logic signed [23:0] center_x;
    logic signed [23:0] center_y;
    logic signed [23:0] center_z;
    logic [24:0]        sphere_radius_out;
    logic               overflow;
  } out_word_t;

  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
  } pt_t;

  // squared-distance unit request
  typedef struct packed {
    logic start;
    pt_t  a;
    pt_t  b;
  } dsq_req_t;

  function automatic logic signed [23:0] sat24(input logic signed [26:0] v);
    logic signed [26:0] hi;
    logic signed [26:0] lo;
    hi = 27'sd8388607;
    lo = -27'sd8388608;
    if (v > hi) return 24'sh7fffff;
    if (v < lo) return 24'sh800000;
    return v[23:0];
  endfunction

endpackage

/* rtl/core/ritter_bounding_sphere_core.sv */
// ritter bounding sphere over a set of 3d points, signed q12.12
//
// input channel: one word per point (x, y, z, last_point) on in_valid /
// in_stall. while loading, a point is taken every cycle and written to the
// point memory; per-axis extreme points are tracked in registers.
// the word flagged last_point ends the set: the seed sphere is formed and a
// growth pass reads every stored point back from the memory.
// each stored point is read back, its squared distance summed and its
// square root taken; a point lying outside the sphere costs three
// divisions more, one per axis. the root unit is shared by seeding and
// growth, and the divider is shared by all three axes.
// output channel: one word (centre, radius, overflow) per set on out_valid /
// out_stall; the result sits in an output register until taken. the next
// set is loaded meanwhile, but a finished set waits while the register
// still holds an untaken word.
// points beyond capacity are dropped and reported through overflow.
// reset (rst_n low, synchronous) empties the set and clears the output;
// the point memory is not cleared, only entries of the current set are read.
module ritter_bounding_sphere_core
  import rbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  typedef enum logic [3:0] {
    ST_LOAD, ST_SEL, ST_MID, ST_SEED, ST_SEEDW, ST_RD, ST_DSQ,
    ST_SQW, ST_DIV, ST_DIVW, ST_OUT
  } state_t;

  state_t state_r;
  logic [CountW-1:0] cnt_r;
  logic [CountW-1:0] idx_r;
  logic        drop_r;
  pt_t         ext_r [6];
  pt_t         ctr_r;
  logic [24:0] rad_r;
  logic [25:0] d_r;
  logic [25:0] newr_r;
  logic [1:0]  axis_r;
  logic signed [24:0] dl_r [3];
  logic [50:0] acc_r;
  logic [1:0]  sel_r;
  logic        out_valid_r;
  out_word_t   out_r;
  logic [50:0] sepv [3];

  logic        in_acc;
  logic        out_load;
  pt_t         p_in;
  pt_t         rd_pt;
  logic        sq_start, sq_done, dv_start, dv_done;
  logic [50:0] sq_arg;
  logic [25:0] sq_root;
  logic signed [50:0] dv_num;
  logic signed [26:0] dv_q;
  logic signed [24:0] dlt;
  logic [49:0] prod;
  logic [AddrW-1:0] rd_addr;
  logic signed [24:0] dsel;
  logic [26:0] dn;
  logic [25:0] dnew;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_LOAD);
  assign p_in     = '{x: in_word.point_x, y: in_word.point_y, z: in_word.point_z};
  // a finished set goes out once the output register is free or being taken
  assign out_load = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  rbs_store u_store (
    .clk     (clk),
    .wr_en   (in_acc && (cnt_r < CountW'(MaxPoints))),
    .wr_addr (cnt_r[AddrW-1:0]),
    .wr_data (p_in),
    .rd_addr (rd_addr),
    .rd_data (rd_pt)
  );

  assign rd_addr = idx_r[AddrW-1:0];

  rbs_isqrt u_sqrt (
    .clk (clk), .rst_n (rst_n), .start (sq_start), .radicand (sq_arg),
    .done (sq_done), .root (sq_root)
  );

  rbs_div u_div (
    .clk (clk), .rst_n (rst_n), .start (dv_start), .dividend (dv_num),
    .divisor (d_r), .done (dv_done), .quotient (dv_q)
  );

  assign sq_arg   = acc_r;
  // axis_r reads 3 only in the first cycle of either root wait
  assign sq_start = (state_r == ST_SEED && axis_r == 2'd3) ||
                    (state_r == ST_SQW && axis_r == 2'd3);
  assign dv_start = (state_r == ST_DIV);
  assign dv_num   = 51'(dl_r[axis_r] * $signed({1'b0, 26'(newr_r - 26'(rad_r))}));

  // one squared term per cycle, shared multiplier
  always_comb begin
    case (axis_r)
      2'd0:    dsel = 25'(ext_r[{sel_r, 1'b0}].x) - 25'(ext_r[{sel_r, 1'b1}].x);
      2'd1:    dsel = 25'(ext_r[{sel_r, 1'b0}].y) - 25'(ext_r[{sel_r, 1'b1}].y);
      default: dsel = 25'(ext_r[{sel_r, 1'b0}].z) - 25'(ext_r[{sel_r, 1'b1}].z);
    endcase
    if (state_r == ST_SEED || state_r == ST_SEEDW) begin
      case (axis_r)
        2'd0:    dlt = 25'(ctr_r.x) - 25'(ext_r[{sel_r, 1'b1}].x);
        2'd1:    dlt = 25'(ctr_r.y) - 25'(ext_r[{sel_r, 1'b1}].y);
        default: dlt = 25'(ctr_r.z) - 25'(ext_r[{sel_r, 1'b1}].z);
      endcase
    end else begin
      // growth pass: term for axis n is summed while axis_r is n+1
      case (axis_r)
        2'd1:    dlt = dl_r[0];
        2'd2:    dlt = dl_r[1];
        default: dlt = dl_r[2];
      endcase
    end
    prod = 50'(dlt * dlt);
    dn   = 27'(sq_root) + 27'(rad_r);
    dnew = dn[26:1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
      ctr_r       <= '0;
      rad_r       <= '0;
      axis_r      <= '0;
    end else begin
      // output register: refilled as the old word leaves, else emptied
      if (out_load) begin
        out_r.center_x          <= ctr_r.x;
        out_r.center_y          <= ctr_r.y;
        out_r.center_z          <= ctr_r.z;
        out_r.sphere_radius_out <= rad_r;
        out_r.overflow          <= drop_r;
        out_valid_r             <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_LOAD: begin
          if (in_acc) begin
            if (cnt_r < CountW'(MaxPoints)) begin
              if (cnt_r == '0) begin
                for (int k = 0; k < 6; k++) ext_r[k] <= p_in;
              end else begin
                if (p_in.x < ext_r[0].x) ext_r[0] <= p_in;
                if (p_in.x > ext_r[1].x) ext_r[1] <= p_in;
                if (p_in.y < ext_r[2].y) ext_r[2] <= p_in;
                if (p_in.y > ext_r[3].y) ext_r[3] <= p_in;
                if (p_in.z < ext_r[4].z) ext_r[4] <= p_in;
                if (p_in.z > ext_r[5].z) ext_r[5] <= p_in;
              end
              cnt_r <= cnt_r + 1'b1;
            end else begin
              drop_r <= 1'b1;
            end
            if (in_word.last_point) begin
              state_r <= ST_SEL;
              sel_r   <= 2'd0;
              axis_r  <= 2'd0;
              acc_r   <= '0;
              dl_r[0] <= '0;
            end
          end
        end
        ST_SEL: begin
          // squared pair separations, one term per axis, accumulated per pair
          if (axis_r == 2'd2) begin
            axis_r <= 2'd0;
            acc_r  <= '0;
            // store the three sums in a small result vector
            sepv[sel_r] <= acc_r + 51'(50'(dsel * dsel));
            if (sel_r == 2'd2) state_r <= ST_MID;
            sel_r <= sel_r + 2'd1;
          end else begin
            acc_r  <= acc_r + 51'(50'(dsel * dsel));
            axis_r <= axis_r + 2'd1;
          end
        end
        ST_MID: begin
          if (sepv[1] > sepv[0] && sepv[1] > sepv[2]) sel_r <= 2'd1;
          else if (sepv[2] > sepv[0] && sepv[2] > sepv[1]) sel_r <= 2'd2;
          else sel_r <= 2'd0;
          state_r <= ST_SEEDW;
          axis_r  <= 2'd3;
        end
        ST_SEEDW: begin
          if (axis_r == 2'd3) begin
            ctr_r.x <= 24'(($signed(25'(ext_r[{sel_r,1'b0}].x)) +
                            $signed(25'(ext_r[{sel_r,1'b1}].x))) / 2);
            ctr_r.y <= 24'(($signed(25'(ext_r[{sel_r,1'b0}].y)) +
                            $signed(25'(ext_r[{sel_r,1'b1}].y))) / 2);
            ctr_r.z <= 24'(($signed(25'(ext_r[{sel_r,1'b0}].z)) +
                            $signed(25'(ext_r[{sel_r,1'b1}].z))) / 2);
            axis_r  <= 2'd0;
            acc_r   <= '0;
          end else begin
            acc_r <= acc_r + 51'(prod);
            if (axis_r == 2'd2) begin
              axis_r  <= 2'd3;
              state_r <= ST_SEED;
            end else begin
              axis_r <= axis_r + 2'd1;
            end
          end
        end
        ST_SEED: begin
          // root started in the first cycle of this state
          if (sq_done) begin
            rad_r   <= (sq_root > 26'd33554431) ? 25'h1ffffff : sq_root[24:0];
            idx_r   <= '0;
            state_r <= (cnt_r == '0) ? ST_OUT : ST_RD;
            axis_r  <= 2'd0;
          end else begin
            axis_r <= 2'd0;
          end
        end
        ST_RD: begin
          // memory read issued, data valid next cycle
          axis_r  <= 2'd0;
          acc_r   <= '0;
          state_r <= ST_DSQ;
        end
        ST_DSQ: begin
          if (axis_r == 2'd0) begin
            dl_r[0] <= 25'(rd_pt.x) - 25'(ctr_r.x);
            dl_r[1] <= 25'(rd_pt.y) - 25'(ctr_r.y);
            dl_r[2] <= 25'(rd_pt.z) - 25'(ctr_r.z);
            axis_r  <= 2'd1;
          end else begin
            acc_r <= acc_r + 51'(prod);
            if (axis_r == 2'd3) begin
              state_r <= ST_SQW;
            end else begin
              axis_r <= axis_r + 2'd1;
            end
          end
        end
        ST_SQW: begin
          if (sq_done) begin
            if ({1'b0, sq_root} > {2'b00, rad_r}) begin
              d_r     <= sq_root;
              newr_r  <= dnew;
              axis_r  <= 2'd0;
              state_r <= ST_DIV;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= (idx_r + 1'b1 == cnt_r) ? ST_OUT : ST_RD;
            end
          end else begin
            axis_r <= 2'd0;
          end
        end
        ST_DIV: state_r <= ST_DIVW;
        ST_DIVW: begin
          if (dv_done) begin
            case (axis_r)
              2'd0:    ctr_r.x <= sat24(27'(ctr_r.x) + dv_q);
              2'd1:    ctr_r.y <= sat24(27'(ctr_r.y) + dv_q);
              default: ctr_r.z <= sat24(27'(ctr_r.z) + dv_q);
            endcase
            if (axis_r == 2'd2) begin
              rad_r   <= (newr_r > 26'd33554431) ? 25'h1ffffff : newr_r[24:0];
              idx_r   <= idx_r + 1'b1;
              state_r <= (idx_r + 1'b1 == cnt_r) ? ST_OUT : ST_RD;
            end else begin
              axis_r  <= axis_r + 2'd1;
              state_r <= ST_DIV;
            end
          end
        end
        ST_OUT: begin
          if (out_load) begin
            cnt_r   <= '0;
            drop_r  <= 1'b0;
            state_r <= ST_LOAD;
          end
        end
        default: state_r <= ST_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_LOAD) |-> in_stall)
    else $error("input taken outside loading");
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CountW'(MaxPoints))
    else $error("point count beyond capacity");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_r)))
    else $error("stalled result changed");
`endif

endmodule

/* rtl/core/rbs_isqrt.sv */
// iterative integer square root, one result bit per cycle
module rbs_isqrt
  import rbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [50:0] radicand,
  output logic        done,
  output logic [25:0] root
);

  logic [50:0] rem_r, rem_nxt;
  logic [50:0] res_r, res_nxt;
  logic [4:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [51:0] trial;
  logic [50:0] bit_v;

  always_comb begin
    bit_v    = 51'd1 << {step_r, 1'b0};
    trial    = {1'b0, res_r} + {1'b0, bit_v};
    rem_nxt  = rem_r;
    res_nxt  = res_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = radicand;
      res_nxt  = '0;
      step_nxt = 5'd25;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // res holds r scaled by 2^step
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt = rem_r - trial[50:0];
        res_nxt = (res_r >> 1) + bit_v;
      end else begin
        res_nxt = res_r >> 1;
      end
      if (step_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        step_nxt = step_r - 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    res_r  <= res_nxt;
    step_r <= step_nxt;
  end

  assign done = done_r;
  assign root = res_r[25:0];

endmodule

/* rtl/core/rbs_div.sv */
// restoring signed divider, quotient truncated toward zero, one bit per cycle
module rbs_div
  import rbs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [50:0] dividend,
  input  logic [25:0]        divisor,
  output logic               done,
  output logic signed [26:0] quotient
);

  logic [50:0] mag_r, mag_nxt;
  logic [26:0] rem_r, rem_nxt;
  logic [25:0] dvs_r, dvs_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [26:0] sh;
  logic [50:0] q;

  always_comb begin
    mag_nxt  = mag_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[25:0], mag_r[50]};
    if (start) begin
      mag_nxt  = dividend[50] ? 51'(-dividend) : dividend;
      neg_nxt  = dividend[50];
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = 6'd51;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = sh - {1'b0, dvs_r};
        mag_nxt = {mag_r[49:0], 1'b1};
      end else begin
        rem_nxt = sh;
        mag_nxt = {mag_r[49:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    mag_r <= mag_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

  // |delta*num/d| < |delta| so it fits 27 bits
  assign q        = neg_r ? 51'(-mag_r) : mag_r;
  assign quotient = q[26:0];
  assign done     = done_r;

endmodule

/* rtl/core/rbs_store.sv */
// point memory, one write port and one registered read port
module rbs_store
  import rbs_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  pt_t              wr_data,
  input  logic [AddrW-1:0] rd_addr,
  output pt_t              rd_data
);

  pt_t mem [MaxPoints];
  pt_t rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_data = rd_r;

endmodule
